// ===== src/stereo_comb_allpass_reverb_defines.svh =====
// ----------------------------------------------------------------------------
// reverb assertion macros
// shared assertion forms for the reverb block
// ----------------------------------------------------------------------------
`ifndef STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH
`define STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SCAR_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");

// next-cycle implication
`define SCAR_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");

`endif

// ===== src/scar_pkg.sv =====
// ----------------------------------------------------------------------------
// scar_pkg
// constants, line tables and fixed-point helpers of the reverb
// ----------------------------------------------------------------------------
package scar_pkg;

    localparam int SW          = 24;
    localparam int CW          = 16;
    localparam int NCOMB       = 8;
    localparam int NAP         = 4;
    localparam int CSTORE      = 32768;
    localparam int ASTORE      = 4096;
    localparam int CAW         = 15;
    localparam int AAW         = 12;
    localparam int CLW         = 13;
    localparam int ALW         = 10;
    localparam int FS          = 48000;
    localparam int SPREAD      = (FS / 2000 < 1) ? 1 : FS / 2000;

    localparam logic [CW-1:0] GAIN_MAX = 16'd64553;
    localparam logic [CW-1:0] DAMP_MAX = 16'd58982;
    localparam logic [CW-1:0] DIFF_MAX = 16'd45875;
    localparam logic [CW-1:0] POLE_MAX = 16'd65529;

    localparam logic [2:0] REG_SIZE  = 3'd0;
    localparam logic [2:0] REG_GL_LO = 3'd1;
    localparam logic [2:0] REG_GL_HI = 3'd2;
    localparam logic [2:0] REG_GR_LO = 3'd3;
    localparam logic [2:0] REG_GR_HI = 3'd4;
    localparam logic [2:0] REG_TONE  = 3'd5;
    localparam logic [2:0] REG_CHAN  = 3'd6;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    typedef logic signed [SW-1:0] smp_t;

    typedef struct packed {
        smp_t in_l;
        smp_t in_r;
        logic stereo;
    } req_t;

    function automatic logic [9:0] comb_tenths(input logic [2:0] c);
        logic [9:0] t;
        case (c)
            3'd0: t = 10'd297;
            3'd1: t = 10'd319;
            3'd2: t = 10'd341;
            3'd3: t = 10'd367;
            3'd4: t = 10'd391;
            3'd5: t = 10'd413;
            3'd6: t = 10'd437;
            default: t = 10'd461;
        endcase
        return t;
    endfunction

    function automatic logic [9:0] ap_tenths(input logic [1:0] a);
        logic [9:0] t;
        case (a)
            2'd0: t = 10'd97;
            2'd1: t = 10'd73;
            2'd2: t = 10'd59;
            default: t = 10'd43;
        endcase
        return t;
    endfunction

    function automatic logic [CLW-1:0] comb_cap(input logic [2:0] c);
        int v;
        v = int'(comb_tenths(c)) * FS / 10000 + SPREAD + 2;
        if (v > 4096) v = 4096;
        return CLW'(v);
    endfunction

    function automatic logic [ALW-1:0] ap_cap(input logic [1:0] a);
        int v;
        v = int'(ap_tenths(a)) * FS / 10000 + SPREAD + 2;
        if (v > 512) v = 512;
        return ALW'(v);
    endfunction

    function automatic logic [CAW-1:0] comb_base(input logic [3:0] i);
        int off;
        off = 0;
        for (int k = 0; k < 16; k++)
            if (k < int'(i)) off = off + int'(comb_cap(3'(k)));
        return CAW'(off);
    endfunction

    function automatic logic [AAW-1:0] ap_base(input logic [2:0] i);
        int off;
        off = 0;
        for (int k = 0; k < 8; k++)
            if (k < int'(i)) off = off + int'(ap_cap(2'(k)));
        return AAW'(off);
    endfunction

    // len = tenths * FS * size / (10000 * 2^16): a shift by 20, then / 625
    // as a reciprocal multiply, exact for shifted values below 2^22
    localparam longint LEN_K     = FS;
    localparam int     LEN_PRE   = 20;
    localparam int     LEN_RECIP = 3435974;
    localparam int     LEN_SHIFT = 31;

    function automatic smp_t sat48(input logic signed [47:0] v);
        smp_t r;
        if (v > 48'(SMAX)) r = SMAX;
        else if (v < 48'(SMIN)) r = SMIN;
        else r = v[SW-1:0];
        return r;
    endfunction

    function automatic logic [CW-1:0] clip(input logic [CW-1:0] v,
                                          input logic [CW-1:0] m);
        return (v > m) ? m : v;
    endfunction

endpackage

// ===== src/scar_front.sv =====
// ----------------------------------------------------------------------------
// scar_front
// input acceptance, channel mode tagging and two-entry request queue
// ----------------------------------------------------------------------------
module scar_front
    import scar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  smp_t in_left,
    input  smp_t in_right,
    input  logic stereo,
    output logic q_valid,
    output req_t q_req,
    input  logic q_take
);
    req_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= !wr_reg;
            if (q_take) rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= '{in_l: in_left, in_r: in_right, stereo: stereo};
    end
endmodule

// ===== src/scar_back.sv =====
// ----------------------------------------------------------------------------
// scar_back
// sequencer that walks combs, allpasses and the width mix for one request
// ----------------------------------------------------------------------------
module scar_back
    import scar_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  req_t           q_req,
    output logic           q_take,
    input  logic [CW-1:0]  size_factor,
    input  logic [255:0]   gains,
    input  logic [63:0]    tone,
    input  logic           size_wr,
    output logic           out_valid,
    input  logic           out_stall,
    output smp_t           out_left,
    output smp_t           out_right
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CRD   = 11'b00000000010,
        S_CLP   = 11'b00000000100,
        S_CHP   = 11'b00000001000,
        S_CWR   = 11'b00000010000,
        S_ARD   = 11'b00000100000,
        S_AV    = 11'b00001000000,
        S_AY    = 11'b00010000000,
        S_MIX   = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_CLR   = 11'b10000000000
    } st_t;

    st_t st_reg, st_next;

    smp_t cmem [CSTORE];
    smp_t amem [ASTORE];
    smp_t crd_reg, ard_reg;

    logic [CLW-1:0] cpos_reg [16];
    logic [ALW-1:0] apos_reg [8];
    logic [CLW-1:0] clen_reg [16];
    logic [ALW-1:0] alen_reg [8];
    smp_t lp_reg [16];
    smp_t hx_reg [16];
    smp_t hy_reg [16];

    logic [CAW-1:0] clr_reg;
    logic           ch_reg;
    logic [2:0]     k_reg;
    logic           lenupd_reg;
    logic [4:0]     li_reg;
    smp_t           x_reg, xr_reg, yl_reg, sum_v;
    logic           stereo_reg;
    logic signed [SW+3:0] acc_reg;
    smp_t           lpn_reg, hn_reg, v_reg, mixl_reg, mixr_reg;
    logic           ob_reg;

    logic [3:0] ci;
    logic [2:0] ai;
    logic [CW-1:0] damp, diff, pole, wdt, g;
    logic [CAW-1:0] caddr;
    logic [AAW-1:0] aaddr;

    assign damp = clip(tone[15:0], DAMP_MAX);
    assign diff = clip(tone[31:16], DIFF_MAX);
    assign pole = clip(tone[47:32], POLE_MAX);
    assign wdt  = tone[63:48];
    assign ci   = {ch_reg, k_reg};
    assign ai   = {ch_reg, k_reg[1:0]};
    assign g    = clip(gains[{ci, 4'd0} +: 16], GAIN_MAX);
    assign caddr = comb_base(ci) + CAW'(cpos_reg[ci]);
    assign aaddr = ap_base(ai) + AAW'(apos_reg[ai]);
    assign sum_v = acc_reg[SW+2:3];

    // arithmetic of each step
    logic signed [47:0] lp_w, hp_w, wr_w, av_w, ay_w, ml_w, mr_w;
    logic signed [SW:0] dlp, dhx;
    always_comb
    begin
        dlp  = {crd_reg[SW-1], crd_reg} - {lp_reg[ci][SW-1], lp_reg[ci]};
        lp_w = 48'(lp_reg[ci]) + ((48'(dlp) * $signed({1'b0, 17'd65536 - 17'(damp)})
               + 48'sd32768) >>> 16);
        dhx  = {lpn_reg[SW-1], lpn_reg} - {hx_reg[ci][SW-1], hx_reg[ci]};
        hp_w = (48'(dhx) * $signed({1'b0, 17'd65536 + 17'(pole)})
               + 48'(hy_reg[ci]) * $signed({1'b0, pole, 1'b0}) + 48'sd65536) >>> 17;
        wr_w = 48'(x_reg) + ((48'(hn_reg) * $signed({1'b0, g}) + 48'sd32768) >>> 16);
        av_w = 48'(sum_v) + ((48'(ard_reg) * $signed({1'b0, diff}) + 48'sd32768) >>> 16);
        ay_w = 48'(ard_reg) - ((48'(v_reg) * $signed({1'b0, diff}) + 48'sd32768) >>> 16);
        ml_w = (48'(yl_reg) * $signed({1'b0, 17'd65536 + 17'(wdt)})
               + 48'(sum_v) * $signed({1'b0, 17'd65536 - 17'(wdt)}) + 48'sd65536) >>> 17;
        mr_w = (48'(sum_v) * $signed({1'b0, 17'd65536 + 17'(wdt)})
               + 48'(yl_reg) * $signed({1'b0, 17'd65536 - 17'(wdt)}) + 48'sd65536) >>> 17;
    end

    // line length of one line, one per cycle after reset or a size write
    logic [9:0]     ltenths;
    logic [25:0]    lscale;
    logic [41:0]    lcalc;
    logic [43:0]    lprod;
    logic [CLW-1:0] lval;
    always_comb
    begin
        ltenths = li_reg[4] ? ap_tenths(li_reg[1:0]) : comb_tenths(li_reg[2:0]);
        lscale  = 26'(32'(ltenths) * 32'(LEN_K));
        lcalc   = 42'(lscale) * 42'(size_factor);
        lprod   = 44'(lcalc[41:LEN_PRE]) * 44'(LEN_RECIP);
        lval    = CLW'(lprod >> LEN_SHIFT);
    end
    logic [CLW:0] lraw, lcap;
    always_comb
    begin
        lcap = '0;
        for (int k = 0; k < NCOMB; k++)
            if (!li_reg[4] && li_reg[2:0] == 3'(k)) lcap = (CLW+1)'(comb_cap(3'(k)));
        for (int k = 0; k < NAP; k++)
            if (li_reg[4] && li_reg[1:0] == 2'(k)) lcap = (CLW+1)'(ap_cap(2'(k)));
        lraw = {1'b0, lval} + ((li_reg[4] ? li_reg[2] : li_reg[3]) ? (CLW+1)'(SPREAD)
                                                                   : '0);
        if (lraw < 2) lraw = 2;
        if (lraw > lcap) lraw = lcap;
    end

    assign q_take    = (st_reg == S_IDLE) && q_valid && !lenupd_reg;
    assign out_valid = ob_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_CLR:  if (clr_reg == CAW'(CSTORE - 1)) st_next = S_IDLE;
            S_IDLE: if (q_take) st_next = S_CRD;
            S_CRD:  st_next = S_CLP;
            S_CLP:  st_next = S_CHP;
            S_CHP:  st_next = S_CWR;
            S_CWR:  st_next = (k_reg == 3'(NCOMB - 1)) ? S_ARD : S_CRD;
            S_ARD:  st_next = S_AV;
            S_AV:   st_next = S_AY;
            S_AY:
            begin
                if (k_reg == 3'(NAP - 1))
                    st_next = (ch_reg || !stereo_reg) ? (ch_reg ? S_MIX : S_OUT) : S_CRD;
                else
                    st_next = S_ARD;
            end
            S_MIX:  st_next = S_OUT;
            S_OUT:  if (!ob_reg || !out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLR;
            clr_reg    <= '0;
            ch_reg     <= 1'b0;
            k_reg      <= '0;
            ob_reg     <= 1'b0;
            lenupd_reg <= 1'b1;
            li_reg     <= '0;
            for (int i = 0; i < 16; i++)
            begin
                cpos_reg[i] <= '0;
                lp_reg[i]   <= '0;
                hx_reg[i]   <= '0;
                hy_reg[i]   <= '0;
                clen_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                apos_reg[i] <= '0;
                alen_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_OUT && (!ob_reg || !out_stall)) ob_reg <= 1'b1;
            else if (!out_stall) ob_reg <= 1'b0;
            if (size_wr)
            begin
                lenupd_reg <= 1'b1;
                li_reg     <= '0;
            end
            else if (lenupd_reg)
            begin
                if (!li_reg[4])
                begin
                    clen_reg[li_reg[3:0]] <= lraw[CLW-1:0];
                    if (cpos_reg[li_reg[3:0]] >= lraw[CLW-1:0]) cpos_reg[li_reg[3:0]] <= '0;
                end
                else
                begin
                    alen_reg[li_reg[2:0]] <= lraw[ALW-1:0];
                    if (apos_reg[li_reg[2:0]] >= lraw[ALW-1:0]) apos_reg[li_reg[2:0]] <= '0;
                end
                li_reg <= li_reg + 5'd1;
                if (li_reg == 5'd23) lenupd_reg <= 1'b0;
            end
            unique case (st_reg)
                S_CLR:  clr_reg <= clr_reg + CAW'(1);
                S_IDLE:
                if (q_take)
                begin
                    ch_reg     <= 1'b0;
                    k_reg      <= '0;
                    acc_reg    <= '0;
                    x_reg      <= q_req.in_l;
                    xr_reg     <= q_req.in_r;
                    stereo_reg <= q_req.stereo;
                end
                S_CLP:  lpn_reg <= sat48(lp_w);
                S_CHP:
                begin
                    hn_reg <= sat48(hp_w);
                    acc_reg <= acc_reg + (SW+4)'(crd_reg);
                end
                S_CWR:
                begin
                    lp_reg[ci] <= lpn_reg;
                    hx_reg[ci] <= lpn_reg;
                    hy_reg[ci] <= hn_reg;
                    cpos_reg[ci] <= (cpos_reg[ci] + CLW'(1) >= clen_reg[ci]) ? '0
                                    : cpos_reg[ci] + CLW'(1);
                    k_reg <= (k_reg == 3'(NCOMB - 1)) ? '0 : k_reg + 3'd1;
                end
                S_AV:   v_reg <= sat48(av_w);
                S_AY:
                begin
                    apos_reg[ai] <= (apos_reg[ai] + ALW'(1) >= alen_reg[ai]) ? '0
                                    : apos_reg[ai] + ALW'(1);
                    k_reg <= (k_reg == 3'(NAP - 1)) ? '0 : k_reg + 3'd1;
                    if (k_reg == 3'(NAP - 1) && !ch_reg && stereo_reg)
                    begin
                        ch_reg  <= 1'b1;
                        x_reg   <= xr_reg;
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= (SW+4)'({sat48(ay_w), 3'b000});
                    if (k_reg == 3'(NAP - 1) && !ch_reg)
                    begin
                        yl_reg <= sat48(ay_w);
                        if (!stereo_reg)
                        begin
                            mixl_reg <= sat48(ay_w);
                            mixr_reg <= '0;
                        end
                    end
                end
                S_MIX:
                begin
                    mixl_reg <= sat48(ml_w);
                    mixr_reg <= sat48(mr_w);
                end
                S_OUT:
                if (!ob_reg || !out_stall)
                begin
                    out_left  <= mixl_reg;
                    out_right <= mixr_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLR)
        begin
            cmem[clr_reg] <= '0;
            amem[clr_reg[AAW-1:0]] <= '0;
        end
        else if (st_reg == S_CWR)
            cmem[caddr] <= sat48(wr_w);
        else if (st_reg == S_AY)
            amem[aaddr] <= v_reg;
        crd_reg <= cmem[caddr];
        ard_reg <= amem[aaddr];
    end
endmodule

// ===== src/stereo_comb_allpass_reverb.sv =====
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// stereo reverb with eight damped combs and four allpasses per channel
// ----------------------------------------------------------------------------
// One request is one stereo sample pair. Each comb takes the read, lowpass,
// highpass and write steps and each allpass the read, v and y steps, on the
// left channel and, in stereo, then on the right, where a width mix step comes
// before the output step. The next request is taken only once the last has
// left the output step, and a result held by a stalled output delays it. Each
// delay memory has one port. After reset a clearing pass zeroes the delay
// memories before the first request is taken; a size write recomputes the 24 line lengths.
module stereo_comb_allpass_reverb
    import scar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  smp_t        in_left,
    input  smp_t        in_right,
    output logic        out_valid,
    input  logic        out_stall,
    output smp_t        out_left,
    output smp_t        out_right,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    `include "stereo_comb_allpass_reverb_defines.svh"

    logic [CW-1:0] size_reg;
    logic [255:0]  gains_reg;
    logic [63:0]   tone_reg;
    logic [1:0]    chan_reg;
    logic          q_valid, q_take, size_wr;
    req_t          q_req;

    assign size_wr = cfg_we && (cfg_index == REG_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 16'hFFFF;
            gains_reg <= '0;
            tone_reg  <= 64'hFFFF000000000000;
            chan_reg  <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE:  size_reg <= cfg_data[CW-1:0];
                REG_GL_LO: gains_reg[63:0]    <= cfg_data;
                REG_GL_HI: gains_reg[127:64]  <= cfg_data;
                REG_GR_LO: gains_reg[191:128] <= cfg_data;
                REG_GR_HI: gains_reg[255:192] <= cfg_data;
                REG_TONE:  tone_reg <= cfg_data;
                REG_CHAN:  chan_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    scar_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_left(in_left), .in_right(in_right), .stereo(chan_reg[1]),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
    );

    scar_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
        .size_factor(size_reg), .gains(gains_reg), .tone(tone_reg), .size_wr(size_wr),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_left(out_left), .out_right(out_right)
    );

    `SCAR_ASSERT_IMP(a_take_needs_valid, q_take, q_valid)
    `SCAR_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_left))
    `SCAR_ASSERT_IMP(a_mono_right_zero, out_valid && !chan_reg[1] && $stable(chan_reg), out_right == '0)
endmodule
